// ===== rtl/fbpa_pkg.sv =====
// Shared types and constants of the fixed-size block pool allocator.
package fbpa_pkg;

  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned DIV_W      = ADDR_W + 1;
  localparam int unsigned CNT_W      = $clog2(DIV_W + 1);
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_REBUILD = 2'd3
  } fbpa_op_e;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIV    = 6'b000010,
    ST_THREAD = 6'b000100,
    ST_POP    = 6'b001000,
    ST_POP2   = 6'b010000,
    ST_RSVD   = 6'b100000
  } fbpa_state_e;

  typedef enum logic [1:0] {
    PUR_COUNT = 2'd0,
    PUR_FREE  = 2'd1
  } fbpa_purpose_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [ADDR_W-1:0] divisor;
  } fbpa_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [ADDR_W-1:0] rem;
  } fbpa_div_rsp_t;

endpackage

// ===== rtl/fbpa_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module fbpa_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fbpa_pkg::fbpa_div_req_t req_i,
  output fbpa_pkg::fbpa_div_rsp_t rsp_o
);

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [fbpa_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [fbpa_pkg::ADDR_W-1:0]   rem_q, rem_d;
  logic [fbpa_pkg::DIV_W-1:0]    quo_q, quo_d;
  logic [fbpa_pkg::ADDR_W-1:0]   dvs_q, dvs_d;
  logic [fbpa_pkg::DIV_W-1:0]    sh;
  logic [fbpa_pkg::DIV_W-1:0]    diff;
  logic                          ge;

  assign sh   = {rem_q, quo_q[fbpa_pkg::DIV_W-1]};
  assign ge   = sh >= {1'b0, dvs_q};
  assign diff = sh - {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = fbpa_pkg::CNT_W'(fbpa_pkg::DIV_W);
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      rem_d = ge ? diff[fbpa_pkg::ADDR_W-1:0] : sh[fbpa_pkg::ADDR_W-1:0];
      quo_d = {quo_q[fbpa_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - fbpa_pkg::CNT_W'(1);
      if (cnt_q == fbpa_pkg::CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Top level of the fixed-size block pool allocator: request sequencer and link memory.
//
// A request is taken when start_i is high and busy_o is low; its single result
// appears on result_addr_o and status_o for exactly one cycle, marked by done_o,
// and cannot be held off. A refusal found at acceptance and a resize that still fits
// set the result register straight from the idle state. An alloc from a sized pool
// reads the link memory in ST_POP and answers from ST_POP2. A free runs its offset
// through a shared bit-serial divider of 33 steps and answers from ST_DIV when the
// divider is done. The first alloc sizes the pool with the same divider and then
// threads the free list one link memory entry per cycle before it pops a slot as
// above; a rebuild sizes and threads the same way and answers once the list is threaded.
// busy_o is low again in the cycle that carries the result, so the next request
// can be taken at the edge that ends it. The link memory holds one entry per
// slot, is not cleared after reset, and is written before it is read.
// Configuration beats (pool_base at index 0, pool_bytes at index 1, other indexes
// ignored) are always accepted and take effect at once.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        op_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]       req_size_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]       block_addr_i,
  output logic                              done_o,
  output logic [fbpa_pkg::ADDR_W-1:0]       result_addr_o,
  output logic                              status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fbpa_pkg::ADDR_W-1:0]       cfg_data_i
);

  // Slot indexes need one code beyond the last slot for the null link.
  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned IW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned AD = fbpa_pkg::ADDR_W;
  localparam int unsigned DW = fbpa_pkg::DIV_W;
  localparam logic [IW-1:0] NULL_IDX = IW'(MAX_SLOTS);

  fbpa_pkg::fbpa_state_e   state_q, state_d;
  fbpa_pkg::fbpa_purpose_e pur_q, pur_d;
  logic          first_q, first_d;
  logic [AD-1:0] cand_q, cand_d;
  logic [IW-1:0] n_q, n_d;
  logic [IW-1:0] thr_q, thr_d;
  logic [AD-1:0] prod_q, prod_d;

  // Pool bookkeeping.
  logic [AD-1:0] obj_q, obj_d;
  logic [IW-1:0] total_q, total_d;
  logic [IW-1:0] free_q, free_d;
  logic [IW-1:0] head_q, head_d;

  // Result register.
  logic          done_q, done_d;
  logic [AD-1:0] res_q, res_d;
  logic          stat_q, stat_d;

  // Configuration registers.
  logic [AD-1:0] base_q;
  logic [AD-1:0] bytes_q;

  // Link memory port signals.
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [IW-1:0] mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [IW-1:0] rd_q;
  logic [IW-1:0] link_mem [MAX_SLOTS];

  fbpa_pkg::fbpa_div_req_t div_req;
  fbpa_pkg::fbpa_div_rsp_t div_rsp;

  logic [DW-1:0]    room;
  logic [DW-1:0]    len;
  logic [DW-1:0]    sum_in;
  logic [DW-1:0]    obj_now;
  logic [IW-1:0]    n_cap;
  logic [IW+AD-1:0] prod_full;
  logic             eff_alloc, eff_free, eff_resize;

  fbpa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The region is clipped at the top of the address space.
  assign room = {1'b1, {AD{1'b0}}} - {1'b0, base_q};
  assign len  = ({1'b0, bytes_q} < room) ? {1'b0, bytes_q} : room;

  // Requested size, raised to one word, plus a word minus one; clearing the bits
  // below the word size rounds it up. The top bit flags a size past 2^32-1.
  assign sum_in = ((DW'(req_size_i) < DW'(fbpa_pkg::WORD_BYTES)) ?
                   DW'(fbpa_pkg::WORD_BYTES) : DW'(req_size_i)) +
                  DW'(fbpa_pkg::WORD_BYTES - 1);
  assign obj_now = sum_in - (sum_in % DW'(fbpa_pkg::WORD_BYTES));

  assign n_cap = (div_rsp.quot > DW'(MAX_SLOTS)) ? NULL_IDX : div_rsp.quot[IW-1:0];

  assign prod_full = (IW + AD)'(head_q) * (IW + AD)'(obj_q);

  // A realloc of a null pointer is an alloc, and a realloc to size zero a free.
  assign eff_alloc  = (op_i == fbpa_pkg::OP_ALLOC) ||
                      ((op_i == fbpa_pkg::OP_REALLOC) && (block_addr_i == '0));
  assign eff_free   = (op_i == fbpa_pkg::OP_FREE) ||
                      ((op_i == fbpa_pkg::OP_REALLOC) && (block_addr_i != '0) &&
                       (req_size_i == '0));
  assign eff_resize = (op_i == fbpa_pkg::OP_REALLOC) && (block_addr_i != '0) &&
                      (req_size_i != '0);

  always_comb begin
    state_d   = state_q;
    pur_d     = pur_q;
    first_d   = first_q;
    cand_d    = cand_q;
    n_d       = n_q;
    thr_d     = thr_q;
    prod_d    = prod_q;
    obj_d     = obj_q;
    total_d   = total_q;
    free_d    = free_q;
    head_d    = head_q;
    done_d    = 1'b0;
    res_d     = res_q;
    stat_d    = stat_q;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    mem_re    = 1'b0;
    mem_ra    = '0;
    div_req   = '0;

    case (state_q)
      fbpa_pkg::ST_IDLE: begin
        if (start_i) begin
          // Refusals found at acceptance and resizes need no division and answer right away.
          done_d = 1'b1;
          res_d  = '0;
          stat_d = 1'b1;
          if (eff_alloc) begin
            if ((req_size_i == '0) || (base_q == '0) || obj_now[AD] ||
                ((obj_q != '0) && (obj_now[AD-1:0] != obj_q))) begin
              state_d = fbpa_pkg::ST_IDLE;
            end else if (obj_q == '0) begin
              // First alloc: size the pool before taking a slot.
              done_d           = 1'b0;
              cand_d           = obj_now[AD-1:0];
              first_d          = 1'b1;
              pur_d            = fbpa_pkg::PUR_COUNT;
              div_req.start    = 1'b1;
              div_req.dividend = len;
              div_req.divisor  = obj_now[AD-1:0];
              state_d          = fbpa_pkg::ST_DIV;
            end else begin
              done_d  = 1'b0;
              state_d = fbpa_pkg::ST_POP;
            end
          end else if (eff_resize) begin
            // The new size fits: the block stays where it is.
            if ((obj_q != '0) && !obj_now[AD] && (obj_now[AD-1:0] <= obj_q)) begin
              res_d  = block_addr_i;
              stat_d = 1'b0;
            end
          end else if (eff_free) begin
            if ((block_addr_i != '0) && (obj_q != '0) && (block_addr_i >= base_q)) begin
              done_d           = 1'b0;
              pur_d            = fbpa_pkg::PUR_FREE;
              div_req.start    = 1'b1;
              div_req.dividend = {1'b0, block_addr_i - base_q};
              div_req.divisor  = obj_q;
              state_d          = fbpa_pkg::ST_DIV;
            end
          end else begin
            // Rebuild of the free list.
            if ((base_q != '0) && (obj_q != '0)) begin
              done_d           = 1'b0;
              first_d          = 1'b0;
              pur_d            = fbpa_pkg::PUR_COUNT;
              div_req.start    = 1'b1;
              div_req.dividend = len;
              div_req.divisor  = obj_q;
              state_d          = fbpa_pkg::ST_DIV;
            end
          end
        end
      end

      fbpa_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          case (pur_q)
            fbpa_pkg::PUR_COUNT: begin
              if (first_q && (n_cap == '0)) begin
                done_d  = 1'b1;
                res_d   = '0;
                stat_d  = 1'b1;
                state_d = fbpa_pkg::ST_IDLE;
              end else begin
                if (first_q) begin
                  obj_d = cand_q;
                end
                n_d     = n_cap;
                thr_d   = '0;
                state_d = fbpa_pkg::ST_THREAD;
              end
            end
            fbpa_pkg::PUR_FREE: begin
              done_d  = 1'b1;
              res_d   = '0;
              state_d = fbpa_pkg::ST_IDLE;
              if ((div_rsp.rem != '0) || (div_rsp.quot >= DW'(total_q)) ||
                  (free_q >= total_q)) begin
                stat_d = 1'b1;
              end else begin
                stat_d = 1'b0;
                mem_we = 1'b1;
                mem_wa = div_rsp.quot[AW-1:0];
                mem_wd = head_q;
                head_d = div_rsp.quot[IW-1:0];
                free_d = free_q + IW'(1);
              end
            end
            default: begin
              state_d = fbpa_pkg::ST_IDLE;
            end
          endcase
        end
      end

      fbpa_pkg::ST_THREAD: begin
        if (thr_q < n_q) begin
          mem_we = 1'b1;
          mem_wa = thr_q[AW-1:0];
          mem_wd = ((thr_q + IW'(1)) < n_q) ? (thr_q + IW'(1)) : NULL_IDX;
          thr_d  = thr_q + IW'(1);
        end else begin
          total_d = n_q;
          free_d  = n_q;
          head_d  = (n_q != '0) ? '0 : NULL_IDX;
          if (first_q) begin
            state_d = fbpa_pkg::ST_POP;
          end else begin
            done_d  = 1'b1;
            res_d   = '0;
            stat_d  = 1'b0;
            state_d = fbpa_pkg::ST_IDLE;
          end
        end
      end

      fbpa_pkg::ST_POP: begin
        if ((head_q >= NULL_IDX) || (free_q == '0)) begin
          done_d  = 1'b1;
          res_d   = '0;
          stat_d  = 1'b1;
          state_d = fbpa_pkg::ST_IDLE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = head_q[AW-1:0];
          prod_d  = prod_full[AD-1:0];
          state_d = fbpa_pkg::ST_POP2;
        end
      end

      fbpa_pkg::ST_POP2: begin
        done_d  = 1'b1;
        res_d   = base_q + prod_q;
        stat_d  = 1'b0;
        head_d  = rd_q;
        free_d  = free_q - IW'(1);
        state_d = fbpa_pkg::ST_IDLE;
      end

      default: begin
        state_d = fbpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fbpa_pkg::ST_IDLE;
      pur_q     <= fbpa_pkg::PUR_COUNT;
      first_q   <= 1'b0;
      n_q       <= '0;
      thr_q     <= '0;
      obj_q     <= '0;
      total_q   <= '0;
      free_q    <= '0;
      head_q    <= NULL_IDX;
      done_q    <= 1'b0;
      base_q    <= '0;
      bytes_q   <= '0;
    end else begin
      state_q   <= state_d;
      pur_q     <= pur_d;
      first_q   <= first_d;
      n_q       <= n_d;
      thr_q     <= thr_d;
      obj_q     <= obj_d;
      total_q   <= total_d;
      free_q    <= free_d;
      head_q    <= head_d;
      done_q    <= done_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == fbpa_pkg::REG_POOL_BASE) begin
          base_q <= cfg_data_i;
        end else if (cfg_index_i == fbpa_pkg::REG_POOL_BYTES) begin
          bytes_q <= cfg_data_i;
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    stat_q <= stat_d;
  end

  // Link memory: one write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= link_mem[mem_ra];
    end
  end

  assign busy_o        = (state_q != fbpa_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign result_addr_o = res_q;
  assign status_o      = stat_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ===== rtl/fbpa_checker.sv =====
// Port-level checks of the block pool allocator and their binding to the top level.
module fbpa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic                        status_o,
  input logic [fbpa_pkg::ADDR_W-1:0] result_addr_o
);

  // An accepted request either starts work or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted request neither started nor answered");

  // A refused request never hands out an address.
  a_refusal_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (result_addr_o == '0))
    else $error("refused request returned a non-null address");

  // A result beat only follows an accepted request or work in progress.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start_i && !busy_o) || $past(busy_o)))
    else $error("result beat without a request");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .result_addr_o (result_addr_o)
);

// ===== sim/tb_fixed_block_pool_allocator.sv =====
// Self-checking testbench for the block pool allocator: directed corner cases, then random phases.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator;

  // The block is built with its default slot cap; the checker keeps its own copy of that size.
  localparam int unsigned MAX_SLOTS = 1024;
  localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS + 1);

  // Status codes carried on status_o.
  localparam bit REPLY_DONE    = 1'b0;
  localparam bit REPLY_REFUSED = 1'b1;

  // Register indexes past the two real registers; beats to them must change nothing.
  localparam logic [fbpa_pkg::CFG_IDX_W-1:0] REG_SPARE_A = fbpa_pkg::CFG_IDX_W'(2);
  localparam logic [fbpa_pkg::CFG_IDX_W-1:0] REG_SPARE_B = fbpa_pkg::CFG_IDX_W'(3);

  // One reply of the block: the returned address and the status, plus a running tag so a
  // mismatch line can name the request it belongs to.
  typedef struct {
    bit [fbpa_pkg::ADDR_W-1:0] result_addr;
    bit                        status;
    int unsigned               tag;
  } pool_reply_t;

  // The scoreboard keeps a shadow copy of the allocator (registers, object size, slot counts,
  // free-list head and link memory) and the queue of replies the block still owes.
  class pool_scoreboard;
    bit [fbpa_pkg::ADDR_W-1:0] pool_base;
    bit [fbpa_pkg::ADDR_W-1:0] pool_bytes;
    bit [fbpa_pkg::ADDR_W-1:0] object_bytes;
    bit [SLOT_W-1:0]           slot_total;
    bit [SLOT_W-1:0]           slots_free;
    bit [SLOT_W-1:0]           list_head;
    bit [SLOT_W-1:0]           next_free [MAX_SLOTS];
    pool_reply_t               awaited [$];
    int unsigned               accepted;
    int unsigned               errors;

    function new();
      pool_base    = '0;
      pool_bytes   = '0;
      object_bytes = '0;
      slot_total   = '0;
      slots_free   = '0;
      list_head    = SLOT_W'(MAX_SLOTS);
      accepted     = 0;
      errors       = 0;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $time, what);
    endtask

    function void set_reg(logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                          logic [fbpa_pkg::ADDR_W-1:0] data);
      case (idx)
        fbpa_pkg::REG_POOL_BASE:  pool_base  = data;
        fbpa_pkg::REG_POOL_BYTES: pool_bytes = data;
        default: ;
      endcase
    endfunction

    // Size rounded up to whole words, never below one word; zero when it would pass 2^32-1.
    function bit [fbpa_pkg::ADDR_W-1:0] rounded_size(bit [fbpa_pkg::ADDR_W-1:0] sz);
      bit [63:0] s;
      s = (sz < fbpa_pkg::WORD_BYTES) ? 64'(fbpa_pkg::WORD_BYTES) : 64'(sz);
      s = ((s + fbpa_pkg::WORD_BYTES - 1) / fbpa_pkg::WORD_BYTES) * fbpa_pkg::WORD_BYTES;
      return (s > 64'hFFFF_FFFF) ? '0 : s[fbpa_pkg::ADDR_W-1:0];
    endfunction

    // Slots of the given size in the region, with the region clipped at the top of the
    // address space and the count capped at the size of the link memory.
    function bit [SLOT_W-1:0] slots_that_fit(bit [fbpa_pkg::ADDR_W-1:0] obj);
      bit [63:0] room;
      bit [63:0] span;
      bit [63:0] n;
      room = 64'h1_0000_0000 - 64'(pool_base);
      span = 64'(pool_bytes);
      if (span > room) span = room;
      n = span / 64'(obj);
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      return n[SLOT_W-1:0];
    endfunction

    // Links every slot to the next one and puts them all on the free list.
    function void thread_slots(bit [SLOT_W-1:0] n);
      for (int unsigned i = 0; i < n; i++)
        next_free[i] = (i + 1 < n) ? SLOT_W'(i + 1) : SLOT_W'(MAX_SLOTS);
      slot_total = n;
      slots_free = n;
      list_head  = (n != 0) ? '0 : SLOT_W'(MAX_SLOTS);
    endfunction

    // Pops a slot off the free list; the very first success also sizes the pool.
    function bit take_slot(bit [fbpa_pkg::ADDR_W-1:0] sz,
                           output bit [fbpa_pkg::ADDR_W-1:0] addr);
      bit [fbpa_pkg::ADDR_W-1:0] obj;
      bit [SLOT_W-1:0]           n;
      addr = '0;
      if (sz == 0 || pool_base == 0) return 1'b0;
      obj = rounded_size(sz);
      if (obj == 0) return 1'b0;
      if (object_bytes == 0) begin
        n = slots_that_fit(obj);
        if (n == 0) return 1'b0;
        object_bytes = obj;
        thread_slots(n);
      end
      if (obj != object_bytes) return 1'b0;
      if (list_head >= MAX_SLOTS || slots_free == 0) return 1'b0;
      addr = fbpa_pkg::ADDR_W'(64'(pool_base) + 64'(list_head) * 64'(object_bytes));
      list_head = next_free[list_head];
      slots_free--;
      return 1'b1;
    endfunction

    // Pushes a slot back on the free list; a second free of the same slot is not caught.
    function bit give_back(bit [fbpa_pkg::ADDR_W-1:0] addr);
      bit [63:0] lo_addr;
      bit [63:0] hi_addr;
      bit [63:0] off;
      bit [63:0] idx;
      if (addr == 0 || object_bytes == 0) return 1'b0;
      lo_addr = 64'(pool_base);
      hi_addr = lo_addr + 64'(slot_total) * 64'(object_bytes);
      if (64'(addr) < lo_addr || 64'(addr) >= hi_addr) return 1'b0;
      off = 64'(addr) - lo_addr;
      if (off % 64'(object_bytes) != 0) return 1'b0;
      if (slots_free >= slot_total) return 1'b0;
      idx = off / 64'(object_bytes);
      if (idx >= MAX_SLOTS) return 1'b0;
      next_free[idx] = list_head;
      list_head      = idx[SLOT_W-1:0];
      slots_free++;
      return 1'b1;
    endfunction

    // Called once per accepted request beat: updates the shadow state and queues the reply.
    function pool_reply_t note_request(fbpa_pkg::fbpa_op_e op, bit [fbpa_pkg::ADDR_W-1:0] sz,
                                       bit [fbpa_pkg::ADDR_W-1:0] addr);
      pool_reply_t               r;
      bit                        ok;
      bit [fbpa_pkg::ADDR_W-1:0] got;
      bit [fbpa_pkg::ADDR_W-1:0] obj;
      ok  = 1'b0;
      got = '0;
      case (op)
        fbpa_pkg::OP_ALLOC: ok = take_slot(sz, got);
        fbpa_pkg::OP_FREE:  ok = give_back(addr);
        fbpa_pkg::OP_REALLOC: begin
          // A null pointer allocates, a zero size frees, and otherwise the same block is
          // handed back as long as the rounded size still fits in one object.
          if (addr == 0) begin
            ok = take_slot(sz, got);
          end else if (sz == 0) begin
            ok = give_back(addr);
          end else if (object_bytes != 0) begin
            obj = rounded_size(sz);
            if (obj != 0 && obj <= object_bytes) begin
              got = addr;
              ok  = 1'b1;
            end
          end
        end
        fbpa_pkg::OP_REBUILD: begin
          if (pool_base != 0 && object_bytes != 0) begin
            thread_slots(slots_that_fit(object_bytes));
            ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.result_addr = got;
      r.status      = ok ? REPLY_DONE : REPLY_REFUSED;
      r.tag         = accepted++;
      awaited.push_back(r);
      return r;
    endfunction

    // Called for every result beat: compares it with the oldest reply still owed.
    task check_result(logic [fbpa_pkg::ADDR_W-1:0] addr, logic status);
      pool_reply_t r;
      if (awaited.size() == 0) begin
        report($sformatf("result addr %h status %b with no request outstanding", addr, status));
        return;
      end
      r = awaited.pop_front();
      if (addr !== r.result_addr)
        report($sformatf("request %0d: result_addr %h, want %h", r.tag, addr, r.result_addr));
      if (status !== r.status)
        report($sformatf("request %0d: status %b, want %b", r.tag, status, r.status));
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start_i;
  logic                           busy_o;
  logic [1:0]                     op_i;
  logic [fbpa_pkg::ADDR_W-1:0]    req_size_i;
  logic [fbpa_pkg::ADDR_W-1:0]    block_addr_i;
  logic                           done_o;
  logic [fbpa_pkg::ADDR_W-1:0]    result_addr_o;
  logic                           status_o;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data_i;

  fixed_block_pool_allocator #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .req_size_i   (req_size_i),
    .block_addr_i (block_addr_i),
    .done_o       (done_o),
    .result_addr_o(result_addr_o),
    .status_o     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  pool_scoreboard  sb;
  pool_reply_t     last_reply;
  bit              start_high;     // mirrors start_i as last driven, so it is lowered once
  int unsigned     burst_left;     // request beats left before the sender takes a break
  int unsigned     obj;            // object size the run settles on, in bytes
  logic [fbpa_pkg::ADDR_W-1:0] live_blocks [$];   // blocks handed out and not yet given back
  logic [fbpa_pkg::ADDR_W-1:0] freed_blocks [$];  // recent frees, reused to provoke double frees

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The receiver cannot stall, so every strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(result_addr_o, status_o);
  end

  // Sender pacing: after each beat either continue the burst or drop start for a random gap.
  // Random gaps land anywhere within a free, and long bursts give
  // stretches where the next request is always waiting.
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(1, 40);
    start_i <= 1'b0;
    start_high = 1'b0;
    repeat (gap) @(posedge clk_i);
    burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 10);
  endtask

  // Presents one request and holds it until the block takes it, then tells the scoreboard and
  // keeps the lists of handed-out and freed blocks that steer the random part.
  task automatic send_req(input fbpa_pkg::fbpa_op_e op,
                          input logic [fbpa_pkg::ADDR_W-1:0] sz,
                          input logic [fbpa_pkg::ADDR_W-1:0] addr);
    pool_reply_t r;
    start_i      <= 1'b1;
    op_i         <= op;
    req_size_i   <= sz;
    block_addr_i <= addr;
    start_high = 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    r = sb.note_request(op, sz, addr);
    last_reply = r;
    if (r.status == REPLY_DONE) begin
      if (op == fbpa_pkg::OP_ALLOC || (op == fbpa_pkg::OP_REALLOC && addr == 0)) begin
        live_blocks.push_back(r.result_addr);
      end else if (op == fbpa_pkg::OP_FREE || (op == fbpa_pkg::OP_REALLOC && sz == 0)) begin
        freed_blocks.push_back(addr);
        if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
      end else if (op == fbpa_pkg::OP_REBUILD) begin
        live_blocks.delete();
        freed_blocks.delete();
      end
    end
    pace();
  endtask

  // Drops start and waits until every owed reply is in and the block is idle again.
  task automatic settle();
    if (start_high) begin
      start_i <= 1'b0;
      start_high = 1'b0;
    end
    while (sb.awaited.size() != 0 || busy_o !== 1'b0) @(posedge clk_i);
  endtask

  // One configuration beat; valid stays up so back-to-back beats need no extra cycle.
  task automatic write_reg(input logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbpa_pkg::ADDR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.set_reg(idx, data);
  endtask

  task automatic set_pool(input logic [fbpa_pkg::ADDR_W-1:0] base,
                          input logic [fbpa_pkg::ADDR_W-1:0] bytes);
    write_reg(fbpa_pkg::REG_POOL_BASE, base);
    write_reg(fbpa_pkg::REG_POOL_BYTES, bytes);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [fbpa_pkg::ADDR_W-1:0] pull_live();
    int unsigned                 i;
    logic [fbpa_pkg::ADDR_W-1:0] a;
    i = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[i];
    live_blocks.delete(i);
    return a;
  endfunction

  // A size that rounds to the object size the pool was built with.
  function automatic logic [fbpa_pkg::ADDR_W-1:0] fitting_size();
    return fbpa_pkg::ADDR_W'(obj - $urandom_range(0, fbpa_pkg::WORD_BYTES - 1));
  endfunction

  // One random request. Most traffic is allocs and frees of real blocks so that the pool
  // fills and drains; the rest is resizes, rebuilds and raw noise on every field.
  task automatic random_item(input int unsigned fill);
    int unsigned                 pick;
    int unsigned                 k;
    logic [fbpa_pkg::ADDR_W-1:0] a;
    logic [fbpa_pkg::ADDR_W-1:0] sz;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_req(fbpa_pkg::fbpa_op_e'($urandom_range(0, 3)), $urandom, $urandom);
    end else if (pick < 10) begin
      send_req(fbpa_pkg::OP_REBUILD, $urandom, $urandom);
    end else if (pick < 20) begin
      k = $urandom_range(0, 4);
      a = (live_blocks.size() != 0) ? live_blocks[$urandom_range(0, live_blocks.size() - 1)]
                                    : $urandom;
      case (k)
        0: send_req(fbpa_pkg::OP_REALLOC, fitting_size(), '0);
        1: begin
          if (live_blocks.size() != 0) a = pull_live();
          send_req(fbpa_pkg::OP_REALLOC, '0, a);
        end
        2: send_req(fbpa_pkg::OP_REALLOC, $urandom_range(1, obj), a);
        3: begin
          sz = $urandom_range(0, 1) ? fbpa_pkg::ADDR_W'(obj + $urandom_range(1, 64))
                                    : $urandom;
          send_req(fbpa_pkg::OP_REALLOC, sz, a);
        end
        default: send_req(fbpa_pkg::OP_REALLOC, $urandom, $urandom);
      endcase
    end else if ($urandom_range(0, 99) < fill) begin
      k = $urandom_range(0, 9);
      if (k == 0) sz = fbpa_pkg::ADDR_W'(obj + fbpa_pkg::WORD_BYTES * $urandom_range(1, 16));
      else if (k == 1) sz = $urandom;
      else sz = fitting_size();
      send_req(fbpa_pkg::OP_ALLOC, sz, $urandom);
    end else begin
      k = $urandom_range(0, 19);
      if (live_blocks.size() != 0 && k < 16) begin
        a = pull_live();
      end else if (freed_blocks.size() != 0 && k < 18) begin
        a = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
      end else begin
        case (k % 3)
          0: a = fbpa_pkg::ADDR_W'(sb.pool_base + $urandom_range(1, obj - 1));
          1: a = fbpa_pkg::ADDR_W'(sb.pool_base + obj * $urandom_range(0, 1100));
          default: a = $urandom;
        endcase
      end
      send_req(fbpa_pkg::OP_FREE, $urandom, a);
    end
  endtask

  initial begin
    logic [fbpa_pkg::ADDR_W-1:0] lead;
    logic [fbpa_pkg::ADDR_W-1:0] base;
    logic [fbpa_pkg::ADDR_W-1:0] bytes;
    int unsigned                 count;
    int unsigned                 fill;

    // Every input is known from time zero; reset is applied once, at the start.
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    op_i         = fbpa_pkg::OP_ALLOC;
    req_size_i   = '0;
    block_addr_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = fbpa_pkg::REG_POOL_BASE;
    cfg_data_i   = '0;
    start_high   = 1'b0;
    burst_left   = 0;
    sb           = new();
    obj          = fbpa_pkg::WORD_BYTES * $urandom_range(1, 8);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unsized pool with a null base: frees, allocs, rebuilds and resizes are all refused.
    send_req(fbpa_pkg::OP_FREE, '0, 32'h0000_0100);
    send_req(fbpa_pkg::OP_ALLOC, 32'd16, '0);
    send_req(fbpa_pkg::OP_REBUILD, '0, '0);
    send_req(fbpa_pkg::OP_REALLOC, 32'd16, '0);
    send_req(fbpa_pkg::OP_REALLOC, 32'd8, 32'h0000_0040);
    settle();

    // Beats to the spare indexes must be dropped. The pool then sits 256 bytes below the
    // top of the address space with a length that runs past it, so the region is clipped.
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    set_pool(32'hFFFF_FF00, 32'hFFFF_FFFF);
    // Zero size, a size whose rounding overflows, and the largest size that still rounds
    // but leaves no room for a single slot: none of them sizes the pool.
    send_req(fbpa_pkg::OP_ALLOC, '0, $urandom);
    send_req(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF, '0);
    send_req(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFF8, '0);
    // This one sizes the pool and threads the free list.
    send_req(fbpa_pkg::OP_ALLOC, fitting_size(), '0);
    lead = last_reply.result_addr;
    // Size mismatch, a resize that no longer fits, one whose rounding overflows, and one
    // that fits and hands back the same block.
    send_req(fbpa_pkg::OP_ALLOC, fbpa_pkg::ADDR_W'(obj + fbpa_pkg::WORD_BYTES), '0);
    send_req(fbpa_pkg::OP_REALLOC, fbpa_pkg::ADDR_W'(obj + 1), lead);
    send_req(fbpa_pkg::OP_REALLOC, 32'hFFFF_FFF9, lead);
    send_req(fbpa_pkg::OP_REALLOC, 32'd1, lead);
    // Bad frees: off a slot boundary, below the pool, and a null pointer.
    send_req(fbpa_pkg::OP_FREE, '0, lead + 1);
    send_req(fbpa_pkg::OP_FREE, '0, 32'h0000_0010);
    send_req(fbpa_pkg::OP_FREE, '0, '0);
    // A zero-size resize frees the block; freeing it again finds no slot in use.
    send_req(fbpa_pkg::OP_REALLOC, '0, lead);
    send_req(fbpa_pkg::OP_FREE, '0, lead);
    settle();

    // A two-slot pool runs dry on the third alloc.
    set_pool(32'hFFFF_FF00, fbpa_pkg::ADDR_W'(2 * obj));
    send_req(fbpa_pkg::OP_REBUILD, '0, '0);
    send_req(fbpa_pkg::OP_ALLOC, fitting_size(), '0);
    send_req(fbpa_pkg::OP_ALLOC, fitting_size(), '0);
    send_req(fbpa_pkg::OP_ALLOC, fitting_size(), '0);
    settle();

    // A region shorter than one object: rebuild empties the pool and still reports success.
    set_pool(32'hFFFF_FF00, fbpa_pkg::ADDR_W'(obj - 1));
    send_req(fbpa_pkg::OP_REBUILD, '0, '0);
    send_req(fbpa_pkg::OP_ALLOC, fitting_size(), '0);
    settle();

    // Rebuild with a null base is refused.
    set_pool('0, fbpa_pkg::ADDR_W'(obj - 1));
    send_req(fbpa_pkg::OP_REBUILD, '0, '0);

    // Random phases. Each one moves the pool to a new place and size while the block is
    // idle, rebuilds the list, and then runs a mix leaning toward allocs or toward frees.
    for (int p = 0; p < 9; p++) begin
      settle();
      case (p)
        0: begin base = 32'h0000_1000; bytes = 32'hFFFF_FFFF; count = 280; end
        1: begin
          base  = $urandom_range(1, 32'hFFFF_0000);
          bytes = fbpa_pkg::ADDR_W'(obj * $urandom_range(1, 12) + $urandom_range(0, obj - 1));
          count = 280;
        end
        2: begin base = 32'h0000_0001; bytes = '0; count = 40; end
        3: begin base = '0; bytes = $urandom; count = 40; end
        4: begin
          base  = 32'hFFFF_FFFF - $urandom_range(0, 4095);
          bytes = 32'hFFFF_FFFF;
          count = 240;
        end
        5: begin base = $urandom_range(1, 32'hFFFF_FFFF); bytes = $urandom; count = 280; end
        6: begin base = 32'hFFFF_FFFF; bytes = $urandom; count = 40; end
        7: begin
          base  = $urandom_range(1, 32'hFFFF_0000);
          bytes = fbpa_pkg::ADDR_W'(obj * $urandom_range(2, 40));
          count = 320;
        end
        default: begin
          base  = $urandom_range(1, 32'hFFFF_0000);
          bytes = fbpa_pkg::ADDR_W'(obj * $urandom_range(1, 12) + $urandom_range(0, obj - 1));
          count = 280;
        end
      endcase
      set_pool(base, bytes);
      send_req(fbpa_pkg::OP_REBUILD, $urandom, $urandom);
      fill = $urandom_range(25, 75);
      for (int i = 0; i < count; i++) random_item(fill);
    end

    // Drain, then leave room for the longest operation in case a stray result follows.
    settle();
    repeat (1200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_fixed_block_pool_allocator: done, clean");
    end else begin
      $display("tb_fixed_block_pool_allocator: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond a run where every request takes the slowest path.
  initial begin
    #40ms;
    $display("tb_fixed_block_pool_allocator: done, errors");
    $finish;
  end

endmodule
